### rtl/core/line_scan_auto_exposure_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line-scan auto-exposure block
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_SCAN_AUTO_EXPOSURE_TOP_ASSERT_SVH
`define LINE_SCAN_AUTO_EXPOSURE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication under an active-low reset.
`define LSAE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("line_scan_auto_exposure: check failed");

// Next-cycle implication under an active-low reset.
`define LSAE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("line_scan_auto_exposure: check failed");

`else

`define LSAE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LSAE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/lsae_pkg.sv
// ----------------------------------------------------------------------------
// lsae_pkg
// Widths, register codes, reset values and lookup tables of the
// line-scan auto-exposure block.
// ----------------------------------------------------------------------------
package lsae_pkg;

    // Field and state widths.
    localparam int RAW_W  = 12;
    localparam int PIX_W  = 8;
    localparam int SUM_W  = 18;
    localparam int TGT_W  = 11;
    localparam int LIM_W  = 12;
    localparam int OFS_W  = 16;
    localparam int EXPO_W = 18;
    localparam int GAIN_W = 13;
    localparam int LN_W   = 11;
    localparam int Z_W    = 8;
    localparam int P_W    = 3;
    localparam int Y_W    = 13;
    localparam int M_W    = 18;
    localparam int K_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Frame length is a power of two, so the mean is a plain shift.
    localparam int PIXELS_LOG2 = 7;
    localparam int ZQ_W = SUM_W - PIXELS_LOG2;

    // Gain arithmetic runs two bits wider than the gain itself.
    localparam int GSUM_W = GAIN_W + 2;

    // log2(e) in Q14, used to turn the natural-log gain into a base-2 one.
    localparam int EXP_SHIFT = 14;
    localparam logic [14:0] LOG2E_Q14 = 15'd23638;
    localparam int YPROD_W = (GAIN_W - 1) + 15;

    // Shifted mantissa width and the shift at which the exposure surely saturates.
    localparam int SHIFT_W = M_W + EXPO_W - 1;
    localparam logic [K_W-1:0] K_SAT = K_W'(EXPO_W);

    // Reset values.
    localparam logic [TGT_W-1:0]  TARGET_LOG_RST      = 11'd1280;
    localparam logic [LIM_W-1:0]  GAIN_LIMIT_RST      = 12'd3072;
    localparam logic [OFS_W-1:0]  EXPOSURE_OFFSET_RST = 16'd4000;
    localparam logic [GAIN_W-1:0] LOG_GAIN_RST        = 13'sd256;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_LOG      = 2'd0,
        REG_GAIN_LIMIT      = 2'd1,
        REG_EXPOSURE_OFFSET = 2'd2
    } t_cfg_reg;

    // Natural log of the mantissa 1 + i/16, Q8.
    function automatic logic [7:0] ln_mant(input logic [4:0] idx);
        logic [7:0] v;
        unique case (idx)
            5'd0:    v = 8'd0;
            5'd1:    v = 8'd16;
            5'd2:    v = 8'd30;
            5'd3:    v = 8'd44;
            5'd4:    v = 8'd57;
            5'd5:    v = 8'd70;
            5'd6:    v = 8'd82;
            5'd7:    v = 8'd93;
            5'd8:    v = 8'd104;
            5'd9:    v = 8'd114;
            5'd10:   v = 8'd124;
            5'd11:   v = 8'd134;
            5'd12:   v = 8'd143;
            5'd13:   v = 8'd152;
            5'd14:   v = 8'd161;
            5'd15:   v = 8'd169;
            5'd16:   v = 8'd177;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // Natural log of 2^p, Q8.
    function automatic logic [LN_W-1:0] ln_oct(input logic [P_W-1:0] p);
        logic [LN_W-1:0] v;
        unique case (p)
            3'd0: v = 11'd0;
            3'd1: v = 11'd177;
            3'd2: v = 11'd355;
            3'd3: v = 11'd532;
            3'd4: v = 11'd710;
            3'd5: v = 11'd887;
            3'd6: v = 11'd1065;
            3'd7: v = 11'd1242;
        endcase
        return v;
    endfunction

    // 2^(j/16), Q16.
    function automatic logic [M_W-1:0] exp_mant(input logic [4:0] idx);
        logic [M_W-1:0] v;
        unique case (idx)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88753;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            5'd16:   v = 18'd131072;
            default: v = 18'd65536;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/lsae_ln.sv
// ----------------------------------------------------------------------------
// lsae_ln
// Natural log of an 8-bit mean in Q8: octave from the leading one plus a
// linearly interpolated mantissa table.
// ----------------------------------------------------------------------------
module lsae_ln (
    input  logic [lsae_pkg::Z_W-1:0]  i_z,
    output logic [lsae_pkg::LN_W-1:0] o_ln
);
    import lsae_pkg::*;

    logic [P_W-1:0] lead;
    logic [Z_W-1:0] norm;
    logic [3:0]     seg;
    logic [2:0]     frac;
    logic [7:0]     lo;
    logic [7:0]     hi;
    logic [4:0]     step;
    logic [7:0]     prod;

    // Position of the leading one; a zero input falls to position zero.
    always_comb begin
        lead = '0;
        for (int b = 1; b < Z_W; b++) begin
            if (i_z[b]) begin
                lead = P_W'(b);
            end
        end
    end

    // Normalize to 128..255 and split into table segment and fraction.
    assign norm = i_z << (P_W'(Z_W - 1) - lead);
    assign seg  = norm[6:3];
    assign frac = norm[2:0];

    // Interpolate between neighboring mantissa entries.
    assign lo   = ln_mant({1'b0, seg});
    assign hi   = ln_mant({1'b0, seg} + 5'd1);
    assign step = 5'(hi - lo);
    assign prod = 8'(step * frac);

    assign o_ln = ln_oct(lead) + LN_W'(lo) + LN_W'(prod[7:3]);

endmodule

### rtl/core/lsae_exp.sv
// ----------------------------------------------------------------------------
// lsae_exp
// Mantissa of 2^y for a Q8 base-2 exponent: interpolated Q16 table value
// and the integer shift count.
// ----------------------------------------------------------------------------
module lsae_exp (
    input  logic [lsae_pkg::Y_W-1:0] i_y,
    output logic [lsae_pkg::M_W-1:0] o_mant,
    output logic [lsae_pkg::K_W-1:0] o_shift
);
    import lsae_pkg::*;

    logic [3:0]     seg;
    logic [3:0]     frac;
    logic [M_W-1:0] lo;
    logic [M_W-1:0] hi;
    logic [12:0]    step;
    logic [16:0]    prod;

    // Table segment from the upper fraction bits, weight from the lower ones.
    assign seg  = i_y[7:4];
    assign frac = i_y[3:0];

    assign lo   = exp_mant({1'b0, seg});
    assign hi   = exp_mant({1'b0, seg} + 5'd1);
    assign step = 13'(hi - lo);
    assign prod = 17'(step * frac);

    assign o_mant  = lo + M_W'(prod[16:4]);
    assign o_shift = i_y[Y_W-1:8];

endmodule

### rtl/core/line_scan_auto_exposure_top.sv
// ----------------------------------------------------------------------------
// line_scan_auto_exposure_top
// Log-domain auto-exposure loop for a line-scan camera: sums pixels over a
// frame, updates a clamped log gain at frame end and emits the exposure.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   --------------------------------------
//  pixel     i_valid / o_ready    i_raw_pixel[11:0], i_frame_end
//  result    o_valid / i_ready    o_exposure_time[17:0], o_gain_now[12:0]
//  config    i_cfg_we             i_cfg_index[1:0], i_cfg_data[15:0]
//
// One pixel is taken per cycle while o_ready is high. A frame-end pixel's result
// passes through a six-stage pipeline (sum, ln, gain, base-2 scale, exp
// mantissa, output); the gain stage updates the log gain itself, so frame
// ends may follow each other back to back.
// Reset is synchronous, active low; it clears the sum, the stage valid flags
// and restores the registers and the log gain.
// A stalled result holds the stages behind it only as far as they are full.
// ----------------------------------------------------------------------------
`include "line_scan_auto_exposure_top_assert.svh"

module line_scan_auto_exposure_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Pixel channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [lsae_pkg::RAW_W-1:0]      i_raw_pixel,
    input  logic                            i_frame_end,
    // Result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [lsae_pkg::EXPO_W-1:0]     o_exposure_time,
    output logic signed [lsae_pkg::GAIN_W-1:0] o_gain_now,
    // Configuration
    input  logic                            i_cfg_we,
    input  logic [lsae_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsae_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lsae_pkg::*;

    // Configuration registers
    logic [TGT_W-1:0] r_target_log;
    logic [LIM_W-1:0] r_gain_limit;
    logic [OFS_W-1:0] r_exposure_offset;

    // Pipeline registers
    logic [SUM_W-1:0]         r_sum;
    logic                     r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [Z_W-1:0]           r_z1;
    logic [LN_W-1:0]          r_ln2;
    logic                     r_zero2;
    logic signed [GAIN_W-1:0] r_log_gain;
    logic [Y_W-1:0]           r_y4;
    logic                     r_neg4, r_neg5;
    logic signed [GAIN_W-1:0] r_g4, r_g5;
    logic [M_W-1:0]           r_m5;
    logic [K_W-1:0]           r_k5;
    logic                     r_o_valid;
    logic [EXPO_W-1:0]        r_expo;
    logic signed [GAIN_W-1:0] r_gain_out;

    // Stage load enables
    logic ld1, ld2, ld3, ld4, ld5, ld6;
    logic in_xfer;

    // Stage-1 datapath
    logic [PIX_W-1:0] pix;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] sum_next;
    logic [ZQ_W-1:0]  zq;
    logic [Z_W-1:0]   z_mean;

    // Stage-2..6 datapath
    logic [LN_W-1:0]           ln_val;
    logic signed [GSUM_W-1:0]  g_sum;
    logic signed [GSUM_W-1:0]  g_lim;
    logic signed [GSUM_W-1:0]  g_clamp;
    logic [YPROD_W-1:0]        y_prod;
    logic [M_W-1:0]            mant;
    logic [K_W-1:0]            shift_k;
    logic [SHIFT_W-1:0]        shifted;
    logic [EXPO_W:0]           scaled;
    logic [EXPO_W+1:0]         expo_sum;
    logic [EXPO_W-1:0]         n_expo;

    // Each stage loads when it is empty or when the next stage loads too.
    assign ld6     = !r_o_valid || i_ready;
    assign ld5     = !r_v5 || ld6;
    assign ld4     = !r_v4 || ld5;
    assign ld3     = !r_v3 || ld4;
    assign ld2     = !r_v2 || ld3;
    assign ld1     = !r_v1 || ld2;
    assign o_ready = ld1;
    assign in_xfer = i_valid && ld1;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_log      <= TARGET_LOG_RST;
            r_gain_limit      <= GAIN_LIMIT_RST;
            r_exposure_offset <= EXPOSURE_OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_TARGET_LOG:      r_target_log      <= i_cfg_data[TGT_W-1:0];
                REG_GAIN_LIMIT:      r_gain_limit      <= i_cfg_data[LIM_W-1:0];
                REG_EXPOSURE_OFFSET: r_exposure_offset <= i_cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1: saturating frame sum and the mean of the finished frame.
    assign pix      = i_raw_pixel[RAW_W-1:RAW_W-PIX_W];
    assign sum_add  = {1'b0, r_sum} + (SUM_W + 1)'(pix);
    assign sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    assign zq       = sum_next[SUM_W-1:PIXELS_LOG2];
    assign z_mean   = (zq > ZQ_W'({Z_W{1'b1}})) ? '1 : zq[Z_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_v1  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_sum <= i_frame_end ? '0 : sum_next;
            end
            if (ld1) begin
                r_v1 <= in_xfer && i_frame_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_z1 <= z_mean;
        end
    end

    // Stage 2: natural log of the mean.
    lsae_ln u_ln (
        .i_z  (r_z1),
        .o_ln (ln_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ld2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_ln2   <= ln_val;
            r_zero2 <= (r_z1 == '0);
        end
    end

    // Stage 3: gain update and clamp; a zero mean forces the upper limit.
    assign g_sum = GSUM_W'(r_log_gain) + $signed(GSUM_W'(r_target_log))
                 - $signed(GSUM_W'(r_ln2));
    assign g_lim = $signed(GSUM_W'(r_gain_limit));

    always_comb begin
        priority if (r_zero2) begin
            g_clamp = g_lim;
        end else if (g_sum > g_lim) begin
            g_clamp = g_lim;
        end else if (g_sum < -g_lim) begin
            g_clamp = -g_lim;
        end else begin
            g_clamp = g_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3       <= 1'b0;
            r_log_gain <= LOG_GAIN_RST;
        end else if (ld3) begin
            r_v3 <= r_v2;
            if (r_v2) begin
                r_log_gain <= g_clamp[GAIN_W-1:0];
            end
        end
    end

    // Stage 4: convert the gain to a base-2 exponent.
    assign y_prod = YPROD_W'(r_log_gain[GAIN_W-2:0]) * YPROD_W'(LOG2E_Q14);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (ld4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld4) begin
            r_y4   <= y_prod[EXP_SHIFT +: Y_W];
            r_neg4 <= r_log_gain[GAIN_W-1];
            r_g4   <= r_log_gain;
        end
    end

    // Stage 5: interpolated mantissa and shift count.
    lsae_exp u_exp (
        .i_y     (r_y4),
        .o_mant  (mant),
        .o_shift (shift_k)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (ld5) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld5) begin
            r_m5   <= mant;
            r_k5   <= shift_k;
            r_neg5 <= r_neg4;
            r_g5   <= r_g4;
        end
    end

    // Stage 6: scale, add the offset and saturate into the result register.
    assign shifted  = SHIFT_W'(r_m5) << r_k5;
    assign scaled   = shifted[SHIFT_W-1:16];
    assign expo_sum = (EXPO_W + 2)'(r_exposure_offset) + (EXPO_W + 2)'(scaled);

    always_comb begin
        priority if (r_neg5) begin
            n_expo = EXPO_W'(r_exposure_offset);
        end else if (r_k5 >= K_SAT) begin
            n_expo = '1;
        end else if (expo_sum[EXPO_W+1:EXPO_W] != 2'b00) begin
            n_expo = '1;
        end else begin
            n_expo = expo_sum[EXPO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ld6) begin
            r_o_valid <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld6) begin
            r_expo     <= n_expo;
            r_gain_out <= r_g5;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_exposure_time = r_expo;
    assign o_gain_now      = r_gain_out;

    // Checks on the pipeline and the gain loop.
    `LSAE_ASSERT_NXT(a_sum_clear, i_clk, i_rst_n, in_xfer && i_frame_end, r_sum == '0)
    `LSAE_ASSERT_NXT(a_gain_in_range, i_clk, i_rst_n, ld3 && r_v2 && !r_zero2,
                     ($signed(GSUM_W'(r_log_gain)) <= g_lim) &&
                     ($signed(GSUM_W'(r_log_gain)) >= -g_lim))
    `LSAE_ASSERT_NXT(a_zero_mean, i_clk, i_rst_n, ld3 && r_v2 && r_zero2,
                     $signed(GSUM_W'(r_log_gain)) == g_lim)
    `LSAE_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, !o_ready,
                     r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && r_o_valid)

endmodule

### bench/line_scan_auto_exposure_top_test.sv
// ----------------------------------------------------------------------------
// line_scan_auto_exposure_top_test
// Self-checking bench for the line-scan auto-exposure block. A short table
// walks register extremes and the corner cases of the gain loop, then random
// frames run under three idle mixes. Every exposure result is compared with a result
// typed into the table or a local fixed-point model of the mean, log gain and exposure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_scan_auto_exposure_top_test;

    import lsae_pkg::*;

    localparam int PIXELS      = 1 << PIXELS_LOG2;
    localparam int SUM_CAP     = 262143;
    localparam int EXPO_CAP    = 262143;
    localparam int LOG2E_SCALE = 23638;
    localparam int DRAIN_WAIT  = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MIN_RESULTS = 3;

    // Index with no register behind it; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        logic [EXPO_W-1:0]        expo;
        logic signed [GAIN_W-1:0] gain;
    } t_exposure_result;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_DATA_W-1:0]  data;
        logic                   fe;
        logic [CFG_IDX_W-1:0]   idx;
        logic                   typed;
        t_exposure_result       res;
    } t_stim_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [RAW_W-1:0]             i_raw_pixel;
    logic                         i_frame_end;
    logic                         o_valid;
    logic                         i_ready;
    logic [EXPO_W-1:0]            o_exposure_time;
    logic signed [GAIN_W-1:0]     o_gain_now;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_data;

    // Lookup tables of the log and exp approximations.
    int ln_frac_tbl [17] = '{0, 16, 30, 44, 57, 70, 82, 93, 104, 114, 124, 134, 143,
                             152, 161, 169, 177};
    int ln_oct_tbl [8] = '{0, 177, 355, 532, 710, 887, 1065, 1242};
    longint unsigned exp_frac_tbl [17] = '{65536, 68438, 71468, 74632, 77936, 81386,
                                           84990, 88753, 92682, 96785, 101070, 105545,
                                           110218, 115098, 120194, 125515, 131072};

    // Model copy of the registers and the loop state.
    logic [TGT_W-1:0] cur_target;
    logic [LIM_W-1:0] cur_limit;
    logic [OFS_W-1:0] cur_offset;
    int unsigned      acc_sum;
    int               cur_gain;

    t_exposure_result pending_exposures [$];
    t_stim_row        dir_rows [$];

    int errors;
    int items_sent;
    int results_due;
    int results_seen;
    int cfg_writes;
    int cycle_cnt;
    int send_idle_pct;
    int recv_idle_pct;

    line_scan_auto_exposure_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_raw_pixel     (i_raw_pixel),
        .i_frame_end     (i_frame_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_exposure_time (o_exposure_time),
        .o_gain_now      (o_gain_now),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Cycle counter with a hard stop on a hung run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("Test completed with failures");
            $finish;
        end
    end

    // The result side stalls at random, at the current rate.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Natural log of the frame mean in Q8, by octave plus interpolated mantissa.
    function automatic int nat_log_q8(input int z);
        int p, n, f, i, t;
        p = 7;
        while (p > 0 && ((z >> p) & 1) == 0)
            p--;
        n = (z << (7 - p)) & 255;
        f = n - 128;
        i = f >> 3;
        t = f & 7;
        return ln_oct_tbl[p] + ln_frac_tbl[i] +
               (((ln_frac_tbl[i + 1] - ln_frac_tbl[i]) * t) >> 3);
    endfunction

    // Integer part of exp(g) for a Q8 gain, through a base-2 conversion.
    function automatic longint unsigned exp_floor_q8(input int g);
        longint unsigned y, k, r, j, s, m;
        if (g < 0)
            return 0;
        y = 64'(g);
        y = (y * LOG2E_SCALE) >> 14;
        k = y >> 8;
        r = y & 255;
        j = r >> 4;
        s = r & 15;
        m = exp_frac_tbl[j] + (((exp_frac_tbl[j + 1] - exp_frac_tbl[j]) * s) >> 4);
        if (k > 40)
            k = 40;
        return (m << k) >> 16;
    endfunction

    // Accumulates one pixel; on a frame end, updates the gain and forms the exposure.
    function automatic bit update_exposure(input logic [RAW_W-1:0] raw, input logic fe,
                                           output t_exposure_result res);
        int z, g, lim;
        longint unsigned expo;
        res = '0;
        acc_sum = acc_sum + 32'(raw[RAW_W-1:4]);
        if (acc_sum > SUM_CAP)
            acc_sum = SUM_CAP;
        if (!fe)
            return 1'b0;
        z = acc_sum / PIXELS;
        if (z > 255)
            z = 255;
        acc_sum = 0;
        lim = int'(cur_limit);
        if (z == 0) begin
            g = lim;
        end else begin
            g = cur_gain + int'(cur_target) - nat_log_q8(z);
            if (g > lim)
                g = lim;
            if (g < -lim)
                g = -lim;
        end
        cur_gain = g;
        expo = cur_offset + exp_floor_q8(g);
        if (expo > EXPO_CAP)
            expo = EXPO_CAP;
        res.expo = expo[EXPO_W-1:0];
        res.gain = g[GAIN_W-1:0];
        return 1'b1;
    endfunction

    // Offers one pixel, with random idle cycles first, and records what it causes.
    // Entered and left at a falling edge.
    task automatic push_pixel(input logic [RAW_W-1:0] raw, input logic fe,
                              input logic use_typed, input t_exposure_result typed_res);
        t_exposure_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_raw_pixel <= raw;
        i_frame_end <= fe;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        items_sent++;
        if (update_exposure(raw, fe, res)) begin
            pending_exposures.push_back(use_typed ? typed_res : res);
            results_due++;
        end
        @(negedge i_clk);
    endtask

    // Waits for every expected result, then lets the pipeline empty out.
    task automatic wait_for_drain();
        while (pending_exposures.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // Writes one register once the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_valid <= 1'b0;
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
        if (idx == REG_TARGET_LOG)
            cur_target = data[TGT_W-1:0];
        else if (idx == REG_GAIN_LIMIT)
            cur_limit = data[LIM_W-1:0];
        else if (idx == REG_EXPOSURE_OFFSET)
            cur_offset = data[OFS_W-1:0];
    endtask

    // Table rows: a plain pixel, a frame end with its result typed in, a register write.
    task automatic add_pixel(input logic [RAW_W-1:0] raw, input logic fe);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_PIXEL;
        row.data = CFG_DATA_W'(raw);
        row.fe   = fe;
        dir_rows.push_back(row);
    endtask

    task automatic add_known(input logic [RAW_W-1:0] raw, input int expo, input int gain);
        t_stim_row row;
        row          = '0;
        row.kind     = ROW_PIXEL;
        row.data     = CFG_DATA_W'(raw);
        row.fe       = 1'b1;
        row.typed    = 1'b1;
        row.res.expo = EXPO_W'(expo);
        row.res.gain = GAIN_W'(gain);
        dir_rows.push_back(row);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.data = data;
        dir_rows.push_back(row);
    endtask

    // One frame of random pixels around a random brightness, closed by a frame end.
    // A huge frame is long and bright enough to saturate both the mean and the sum.
    // Short frames dominate so that frame ends come often and crowd the pipeline.
    task automatic send_frame(input bit huge);
        int len, base, spread, pick, v, n;
        bit noisy;
        noisy = 1'b0;
        if (huge) begin
            len    = $urandom_range(1060, 1040);
            base   = 4095;
            spread = 24;
        end else begin
            pick = $urandom_range(99);
            if (pick < 15)
                len = PIXELS;
            else if (pick < 25)
                len = $urandom_range(PIXELS + 32, PIXELS - 28);
            else if (pick < 95)
                len = $urandom_range(8, 1);
            else
                len = $urandom_range(2 * PIXELS + 64, PIXELS + 32);
            base   = $urandom_range(4095);
            spread = $urandom_range(600);
            if ($urandom_range(15) == 0)
                base = $urandom_range(40);
            noisy = ($urandom_range(9) == 0);
        end
        for (n = 0; n < len; n++) begin
            if (noisy) begin
                v = $urandom_range(4095);
            end else begin
                v = $urandom_range(2 * spread);
                v = base + v - spread;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
            end
            push_pixel(v[RAW_W-1:0], n == len - 1, 1'b0, '0);
        end
    endtask

    // A stretch of random frames at one idle mix, with at least MIN_RESULTS frame ends in it.
    task automatic run_phase(input int send_pct, input int recv_pct, input bit with_huge,
                             input int item_goal);
        int start_items, start_res;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_items   = items_sent;
        start_res     = results_due;
        if (with_huge)
            send_frame(1'b1);
        while (items_sent - start_items < item_goal ||
               results_due - start_res < MIN_RESULTS)
            send_frame(1'b0);
    endtask

    // Compares every result transfer with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_exposure_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_exposures.size() == 0) begin
                $display("%0t: unexpected result, exposure %0d gain %0d",
                         $time, o_exposure_time, o_gain_now);
                errors++;
            end else begin
                want = pending_exposures.pop_front();
                results_seen++;
                if (o_exposure_time !== want.expo) begin
                    $display("%0t: exposure_time expected %0d, got %0d",
                             $time, want.expo, o_exposure_time);
                    errors++;
                end
                if (o_gain_now !== want.gain) begin
                    $display("%0t: gain_now expected %0d, got %0d",
                             $time, want.gain, o_gain_now);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        t_stim_row row;
        int n;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_raw_pixel   = '0;
        i_frame_end   = 1'b0;
        i_ready       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        errors        = 0;
        items_sent    = 0;
        results_due   = 0;
        results_seen  = 0;
        cfg_writes    = 0;
        cycle_cnt     = 0;
        send_idle_pct = 17;
        recv_idle_pct = 53;
        cur_target    = 11'd1280;
        cur_limit     = 12'd3072;
        cur_offset    = 16'd4000;
        acc_sum       = 0;
        cur_gain      = 256;

        // Zero mean straight after reset drives the gain to the full limit.
        add_known(12'd0, 166772, 3072);
        add_pixel(12'hFFF, 1'b0);
        add_pixel(12'hFFF, 1'b1);
        add_pixel(12'h555, 1'b0);
        add_pixel(12'hAAA, 1'b1);
        // A zero limit pins the gain at zero; largest offset.
        add_write(REG_GAIN_LIMIT, 16'd0);
        add_write(REG_EXPOSURE_OFFSET, 16'hFFFF);
        add_known(12'd2048, 65536, 0);
        // Highest target pushes the gain up into the clamp; zero offset.
        add_write(REG_TARGET_LOG, 16'd2047);
        add_write(REG_GAIN_LIMIT, 16'd3072);
        add_write(REG_EXPOSURE_OFFSET, 16'd0);
        add_pixel(12'hFFF, 1'b1);
        add_pixel(12'hFFF, 1'b1);
        // Zero target and a small limit: the gain hits the lower clamp and the
        // exposure drops to zero. The write to the spare index must change nothing.
        add_write(REG_TARGET_LOG, 16'd0);
        add_write(REG_GAIN_LIMIT, 16'd100);
        add_write(CFG_IDX_SPARE, 16'hFFFF);
        add_pixel(12'hFFF, 1'b0);
        add_pixel(12'hFFF, 1'b1);
        add_pixel(12'hFFF, 1'b0);
        add_known(12'hFFF, 0, -100);
        // Widest limit with the largest offset saturates the exposure.
        add_write(REG_GAIN_LIMIT, 16'd4095);
        add_write(REG_EXPOSURE_OFFSET, 16'hFFFF);
        add_known(12'd0, 262143, 4095);
        add_pixel(12'd0, 1'b0);
        add_pixel(12'hFFF, 1'b1);
        // A lowered limit clamps a gain that sits above it at the next frame end.
        add_write(REG_GAIN_LIMIT, 16'd50);
        add_pixel(12'hFFF, 1'b1);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table.
        for (n = 0; n < dir_rows.size(); n++) begin
            row = dir_rows[n];
            if (row.kind == ROW_WRITE)
                write_reg(row.idx, row.data);
            else
                push_pixel(row.data[RAW_W-1:0], row.fe, row.typed, row.res);
        end

        // Random frames: sender idles lightly while the receiver stalls often.
        // This stretch opens with the one frame that saturates the sum.
        write_reg(REG_TARGET_LOG, CFG_DATA_W'($urandom_range(2047)));
        write_reg(REG_GAIN_LIMIT, 16'd3072);
        write_reg(REG_EXPOSURE_OFFSET, 16'hFFFF);
        run_phase(17, 53, 1'b1, 1150);

        // The other way round.
        write_reg(REG_TARGET_LOG, CFG_DATA_W'($urandom_range(1500, 800)));
        write_reg(REG_GAIN_LIMIT, CFG_DATA_W'($urandom_range(3071, 1)));
        write_reg(REG_EXPOSURE_OFFSET, 16'd0);
        run_phase(53, 17, 1'b0, 300);

        // Full rate on both sides.
        write_reg(REG_TARGET_LOG, CFG_DATA_W'($urandom_range(2047)));
        write_reg(REG_GAIN_LIMIT, CFG_DATA_W'($urandom_range(3072)));
        write_reg(REG_EXPOSURE_OFFSET, CFG_DATA_W'($urandom_range(65535)));
        run_phase(0, 0, 1'b0, 300);

        i_valid <= 1'b0;
        wait_for_drain();

        $display("Sent %0d pixel transfers, checked %0d of %0d exposure results.",
                 items_sent, results_seen, results_due);
        $display("Made %0d register writes across a directed table and three idle mixes.",
                 cfg_writes);
        if (errors == 0 && pending_exposures.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
